>>> design/tiny_cpu_instruction_step_macros.svh
// Assertion macros used by the port checker of the tiny CPU step block.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef TINY_CPU_INSTRUCTION_STEP_MACROS_SVH
`define TINY_CPU_INSTRUCTION_STEP_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define TCPU_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that stays active during reset.
`define TCPU_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/tcpu_pkg.sv
// Shared types and constants of the tiny CPU step block.
// Used by the top level and by its port checker; depends on nothing.
package tcpu_pkg;

    // Command codes carried in s_tuser.
    localparam logic [1:0] CMD_LOAD_BYTE = 2'd0;
    localparam logic [1:0] CMD_STEP      = 2'd1;
    localparam logic [1:0] CMD_READ_REG  = 2'd2;
    localparam logic [1:0] CMD_READ_BYTE = 2'd3;

    // Opcodes in bits 15:12 of an instruction word.
    localparam logic [3:0] OPC_HALT = 4'd0;
    localparam logic [3:0] OPC_ADDI = 4'd1;
    localparam logic [3:0] OPC_SW   = 4'd2;
    localparam logic [3:0] OPC_LW   = 4'd3;

    localparam int unsigned NUM_REGS  = 8;
    localparam int unsigned REG_IDX_W = 3;

    // Stream widths and result field positions.
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 56;
    localparam int unsigned M_PC_LSB  = 0;
    localparam int unsigned M_RUN_BIT = 16;
    localparam int unsigned M_IW_LSB  = 17;
    localparam int unsigned M_RV_LSB  = 33;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_RD_REG   = 11'b000_0000_0010,
        ST_RD_MEM   = 11'b000_0000_0100,
        ST_FETCH_HI = 11'b000_0000_1000,
        ST_FETCH_LO = 11'b000_0001_0000,
        ST_ADDR     = 11'b000_0010_0000,
        ST_STORE_HI = 11'b000_0100_0000,
        ST_STORE_LO = 11'b000_1000_0000,
        ST_LOAD_HI  = 11'b001_0000_0000,
        ST_LOAD_LO  = 11'b010_0000_0000,
        ST_DONE     = 11'b100_0000_0000
    } state_t;

endpackage

>>> design/tiny_cpu_instruction_step.sv
// Top level of the tiny CPU step block: sequencer, byte memory and register file.
// Depends on tcpu_pkg.
//
// Usage: each transfer on the s_ channel carries one command in s_tuser (load a
// memory byte, step one instruction, read a register, read a memory byte) with
// its operands in s_tdata. Every command yields exactly one transfer on the m_
// channel with the program counter, the run flag, the fetched instruction word
// and the read value. The state lives in a single-port byte memory and a
// single-port register file, both with registered read data; a sequencer
// runs one command at a time over them.
// Load byte and a halted step go straight to the result; a read waits for
// its data. A running step fetches the high and the low byte, then ADDI, SW
// and LW form the address. The steps follow the single memory port: two
// byte reads for the fetch and two byte accesses for a load or store.
// A one-entry input holding register takes the next command while the current
// one runs, and the result register holds a finished result while the receiver
// stalls; the sequencer then waits before writing the next result.
// After reset the memory and the registers are cleared one entry per cycle:
// s_tready stays low until the pass ends. MEM_BYTES must be a power of two.
module tiny_cpu_instruction_step #(
    parameter int unsigned MEM_BYTES = 65536
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: address[15:0], data_byte[23:16], reg_index[26:24], zero fill
    input  logic [tcpu_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: cmd[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: pc_now[15:0], running[16], instr_word[32:17], read_value[48:33],
    // zero fill
    output logic [tcpu_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned ADDR_W = $clog2(MEM_BYTES);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MEM_BYTES - 1);

    // Storage.
    logic [7:0]  mem [MEM_BYTES];
    logic [15:0] rf  [tcpu_pkg::NUM_REGS];

    logic                                mem_we;
    logic [15:0]                         mem_a16;
    logic [ADDR_W-1:0]                   mem_addr;
    logic [7:0]                          mem_wdata;
    logic [7:0]                          mem_q;
    logic                                rf_we;
    logic [tcpu_pkg::REG_IDX_W-1:0]      rf_addr;
    logic [15:0]                         rf_wdata;
    logic [15:0]                         rf_q;

    // Clearing pass after reset.
    logic                clr_active_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;

    // Input holding register.
    logic                hold_valid_reg, hold_valid_next;
    logic [1:0]          hold_cmd_reg;
    logic [15:0]         hold_addr_reg;
    logic [7:0]          hold_data_reg;
    logic [2:0]          hold_ridx_reg;
    logic                s_accept;

    // Sequencer and architectural state.
    tcpu_pkg::state_t    state_reg, state_next;
    logic [15:0]         pc_reg, pc_next;
    logic                run_reg, run_next;
    logic [15:0]         iw_reg, iw_next;
    logic [15:0]         rv_reg, rv_next;
    logic [15:0]         ea_reg, ea_next;
    logic [7:0]          byte_reg, byte_next;

    // Result register.
    logic                                m_valid_reg, m_valid_next;
    logic [tcpu_pkg::M_TDATA_W-1:0]      m_data_reg, m_data_next;

    logic [15:0] iw_full;
    logic [15:0] ea_now;
    logic [15:0] ea_inc;
    logic        out_free;

    assign s_tready = !hold_valid_reg && !clr_active_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    // The low byte of the instruction arrives from memory in ST_FETCH_LO.
    assign iw_full = {iw_reg[15:8], mem_q};
    assign ea_now  = rf_q + {10'd0, iw_reg[5:0]};
    assign ea_inc  = ea_reg + 16'd1;

    // Addresses wrap at 16 bits and then select a byte within the memory.
    assign mem_addr = clr_active_reg ? clr_addr_reg : mem_a16[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_q <= mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf[rf_addr] <= rf_wdata;
        end
        rf_q <= rf[rf_addr];
    end

    always_comb begin
        state_next      = state_reg;
        hold_valid_next = hold_valid_reg;
        pc_next         = pc_reg;
        run_next        = run_reg;
        iw_next         = iw_reg;
        rv_next         = rv_reg;
        ea_next         = ea_reg;
        byte_next       = byte_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_a16         = '0;
        mem_wdata       = '0;
        rf_we           = 1'b0;
        rf_addr         = '0;
        rf_wdata        = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_accept) begin
            hold_valid_next = 1'b1;
        end

        case (state_reg)
            tcpu_pkg::ST_IDLE: begin
                if (hold_valid_reg) begin
                    hold_valid_next = 1'b0;
                    iw_next         = '0;
                    rv_next         = '0;
                    case (hold_cmd_reg)
                        tcpu_pkg::CMD_LOAD_BYTE: begin
                            mem_we     = 1'b1;
                            mem_a16    = hold_addr_reg;
                            mem_wdata  = hold_data_reg;
                            state_next = tcpu_pkg::ST_DONE;
                        end
                        tcpu_pkg::CMD_STEP: begin
                            if (run_reg) begin
                                mem_a16    = pc_reg;
                                state_next = tcpu_pkg::ST_FETCH_HI;
                            end else begin
                                state_next = tcpu_pkg::ST_DONE;
                            end
                        end
                        tcpu_pkg::CMD_READ_REG: begin
                            rf_addr    = hold_ridx_reg;
                            state_next = tcpu_pkg::ST_RD_REG;
                        end
                        default: begin
                            mem_a16    = hold_addr_reg;
                            state_next = tcpu_pkg::ST_RD_MEM;
                        end
                    endcase
                end
            end
            tcpu_pkg::ST_RD_REG: begin
                rv_next    = rf_q;
                state_next = tcpu_pkg::ST_DONE;
            end
            tcpu_pkg::ST_RD_MEM: begin
                rv_next    = {8'd0, mem_q};
                state_next = tcpu_pkg::ST_DONE;
            end
            tcpu_pkg::ST_FETCH_HI: begin
                iw_next[15:8] = mem_q;
                mem_a16       = pc_reg + 16'd1;
                state_next    = tcpu_pkg::ST_FETCH_LO;
            end
            tcpu_pkg::ST_FETCH_LO: begin
                iw_next = iw_full;
                pc_next = pc_reg + 16'd2;
                rf_addr = iw_full[11:9];
                case (iw_full[15:12])
                    tcpu_pkg::OPC_HALT: begin
                        run_next   = 1'b0;
                        state_next = tcpu_pkg::ST_DONE;
                    end
                    tcpu_pkg::OPC_ADDI, tcpu_pkg::OPC_SW, tcpu_pkg::OPC_LW: begin
                        state_next = tcpu_pkg::ST_ADDR;
                    end
                    default: begin
                        state_next = tcpu_pkg::ST_DONE;
                    end
                endcase
            end
            tcpu_pkg::ST_ADDR: begin
                // rs has arrived; the effective address is rs + imm.
                ea_next = ea_now;
                rf_addr = iw_reg[8:6];
                case (iw_reg[15:12])
                    tcpu_pkg::OPC_ADDI: begin
                        // R0 is never written by an instruction, so it always reads zero.
                        rf_we      = (iw_reg[8:6] != '0);
                        rf_wdata   = ea_now;
                        state_next = tcpu_pkg::ST_DONE;
                    end
                    tcpu_pkg::OPC_SW: begin
                        state_next = tcpu_pkg::ST_STORE_HI;
                    end
                    default: begin
                        mem_a16    = ea_now;
                        state_next = tcpu_pkg::ST_LOAD_HI;
                    end
                endcase
            end
            tcpu_pkg::ST_STORE_HI: begin
                mem_we     = 1'b1;
                mem_a16    = ea_reg;
                mem_wdata  = rf_q[15:8];
                byte_next  = rf_q[7:0];
                state_next = tcpu_pkg::ST_STORE_LO;
            end
            tcpu_pkg::ST_STORE_LO: begin
                mem_we     = 1'b1;
                mem_a16    = ea_inc;
                mem_wdata  = byte_reg;
                state_next = tcpu_pkg::ST_DONE;
            end
            tcpu_pkg::ST_LOAD_HI: begin
                byte_next  = mem_q;
                mem_a16    = ea_inc;
                state_next = tcpu_pkg::ST_LOAD_LO;
            end
            tcpu_pkg::ST_LOAD_LO: begin
                rf_we      = (iw_reg[8:6] != '0);
                rf_addr    = iw_reg[8:6];
                rf_wdata   = {byte_reg, mem_q};
                state_next = tcpu_pkg::ST_DONE;
            end
            tcpu_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0, rv_reg, iw_reg, run_reg, pc_reg};
                    state_next   = tcpu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcpu_pkg::ST_IDLE;
            end
        endcase

        // The clearing pass owns both storage ports until it finishes.
        if (clr_active_reg) begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            rf_we     = 1'b1;
            rf_addr   = clr_addr_reg[tcpu_pkg::REG_IDX_W-1:0];
            rf_wdata  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            state_reg      <= tcpu_pkg::ST_IDLE;
            hold_valid_reg <= 1'b0;
            pc_reg         <= '0;
            run_reg        <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == CLR_LAST) begin
                    clr_active_reg <= 1'b0;
                end
            end
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            pc_reg         <= pc_next;
            run_reg        <= run_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            hold_cmd_reg  <= s_tuser;
            hold_addr_reg <= s_tdata[15:0];
            hold_data_reg <= s_tdata[23:16];
            hold_ridx_reg <= s_tdata[26:24];
        end
        iw_reg     <= iw_next;
        rv_reg     <= rv_next;
        ea_reg     <= ea_next;
        byte_reg   <= byte_next;
        m_data_reg <= m_data_next;
    end

endmodule

>>> design/tcpu_checker.sv
// Port checker for the tiny CPU step block, attached to the top level by bind.
// Depends on tcpu_pkg and tiny_cpu_instruction_step_macros.svh.
`include "tiny_cpu_instruction_step_macros.svh"

module tcpu_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tcpu_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result keeps its contents.
    `TCPU_ASSERT(a_result_holds, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result changed while stalled")

    // The clearing pass starts at reset: no input taken, no result shown.
    `TCPU_ASSERT_RST(a_reset_quiet, aclk, (!aresetn) |=> (!s_tready && !m_tvalid), "block active right after reset")

    // The holding register has a single entry.
    `TCPU_ASSERT(a_hold_single, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "second transfer taken while holding register full")

    // A stopped processor only reports a HALT word or no word at all.
    `TCPU_ASSERT(a_halt_word, aclk, aresetn, (m_tvalid && !m_tdata[tcpu_pkg::M_RUN_BIT]) |-> (m_tdata[tcpu_pkg::M_IW_LSB + 12 +: 4] == tcpu_pkg::OPC_HALT), "halted result with a non-HALT word")

    // A step never returns a read value.
    `TCPU_ASSERT(a_word_or_read, aclk, aresetn, (m_tvalid && (m_tdata[tcpu_pkg::M_IW_LSB +: 16] != 16'd0)) |-> (m_tdata[tcpu_pkg::M_RV_LSB +: 16] == 16'd0), "step result carries a read value")

endmodule

bind tiny_cpu_instruction_step tcpu_checker u_tcpu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
